/* design/chacha_reduced_round_correlation_counter_top_defines.svh */
// Assertion macros for the reduced-round ChaCha agreement counter.
// Depends on nothing; a module that uses them must have clk and rst in scope.
`ifndef CHACHA_REDUCED_ROUND_CORRELATION_COUNTER_TOP_DEFINES_SVH
`define CHACHA_REDUCED_ROUND_CORRELATION_COUNTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante
`define CCRC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccrc assertion failed (same cycle)");
// Check that cons holds in the cycle after ante
`define CCRC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccrc assertion failed (next cycle)");
`else
`define CCRC_ASSERT_SAME(name, ante, cons)
`define CCRC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* design/ccrc_pkg.sv */
// Shared types, constants and round functions for the ChaCha agreement counter.
// Used by ccrc_core and the top level; depends on nothing.
`timescale 1ns / 1ps

package ccrc_pkg;

  // Sigma words of the initial state
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // One step is one add, one xor and one rotate of a half quarter-round.
  // Three double rounds give 24 steps, then a column half_a (2) and half_b (2).
  localparam int unsigned NUM_STEPS = 28;
  // Steps done when the input parity and the b words are taken
  localparam int unsigned IP_STEP   = 26;

  localparam int unsigned CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KEY_01 = 2'd0,
    REG_KEY_23 = 2'd1,
    REG_KEY_45 = 2'd2,
    REG_KEY_67 = 2'd3
  } cfg_reg_t;

  typedef logic [3:0][63:0]  key_t;
  typedef logic [15:0][31:0] state_t;
  // Negated b words 4, 6 and 7 kept after the first column half
  typedef logic [2:0][31:0]  kept_b_t;

  typedef struct packed {
    logic [63:0] nonce_low;
    logic [63:0] nonce_high;
    logic        restart;
  } item_t;

  typedef struct packed {
    logic        agree;
    logic [32:0] agree_count;
  } result_t;

  // Status of the last core stage toward the counter
  typedef struct packed {
    logic valid;
    logic restart;
    logic agree;
  } core_out_t;

  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] neg32(logic [31:0] v);
    return 32'd0 - v;
  endfunction

  function automatic state_t init_state(key_t key, item_t it);
    state_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int unsigned k = 0; k < 4; k++) begin
      s[4 + 2 * k] = key[k][31:0];
      s[5 + 2 * k] = key[k][63:32];
    end
    s[12] = it.nonce_low[31:0];
    s[13] = it.nonce_low[63:32];
    s[14] = it.nonce_high[31:0];
    s[15] = it.nonce_high[63:32];
    return s;
  endfunction

  // One step on all four quarters; step is a constant per pipeline stage
  function automatic state_t chacha_step(state_t s, int unsigned step);
    state_t      o;
    int unsigned h;
    int unsigned dsel;
    logic        second;
    logic        is_half_b;
    logic [3:0]  ia, ib, ic, id;
    h         = step >> 1;
    second    = (step & 1) != 0;
    is_half_b = (h & 1) != 0;
    // odd rounds are diagonal, the trailing round is a column round
    dsel      = (((h >> 1) & 1) != 0 && h < 12) ? 1 : 0;
    o         = s;
    for (int unsigned q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = 4'(4 + ((q + dsel) & 3));
      ic = 4'(8 + ((q + 2 * dsel) & 3));
      id = 4'(12 + ((q + 3 * dsel) & 3));
      if (!second) begin
        o[ia] = s[ia] + s[ib];
        o[id] = rotl32(s[id] ^ o[ia], is_half_b ? 8 : 16);
      end else begin
        o[ic] = s[ic] + s[id];
        o[ib] = rotl32(s[ib] ^ o[ic], is_half_b ? 7 : 12);
      end
    end
    return o;
  endfunction

  // Parity of the fixed input mask, taken after the first column half
  function automatic logic mask_parity(state_t s);
    return s[0][19] ^ s[0][18] ^ s[0][12] ^ s[0][7]
         ^ s[8][7]
         ^ s[2][24]
         ^ s[10][26] ^ s[10][12] ^ s[10][6]
         ^ s[3][20] ^ s[3][16] ^ s[3][15] ^ s[3][12]
         ^ s[11][31] ^ s[11][19] ^ s[11][16];
  endfunction

  function automatic logic term_one(logic [31:0] x, logic [31:0] y, int unsigned i);
    logic x1, y1, x2, y2;
    x1 = x[i - 1];
    y1 = y[i - 1];
    x2 = x[i - 2];
    y2 = y[i - 2];
    return x[i] ^ y[i] ^ (x1 & y1) ^ (x1 & x2 & y2) ^ (y1 & x2 & y2);
  endfunction

  function automatic logic term_two(logic [31:0] x, logic [31:0] y, int unsigned i);
    return term_one(x, y, i) ^ x[i - 1] ^ y[i - 1] ^ (x[i - 2] & y[i - 2]);
  endfunction

  // Carry-approximated output parity on the final state and kept b words
  function automatic logic output_parity(state_t s, kept_b_t nb);
    logic [31:0] n12, n14, n15;
    n12 = neg32(s[12]);
    n14 = neg32(s[14]);
    n15 = neg32(s[15]);
    return term_two(s[0], nb[0], 19) ^ term_one(s[0], nb[0], 12)
         ^ term_one(s[0], nb[0], 7)
         ^ term_one(s[8], n12, 7)
         ^ term_one(s[2], nb[1], 24)
         ^ term_one(s[10], n14, 26) ^ term_one(s[10], n14, 12)
         ^ term_one(s[10], n14, 6)
         ^ term_one(s[3], nb[2], 20) ^ term_two(s[3], nb[2], 16)
         ^ term_one(s[3], nb[2], 12)
         ^ term_one(s[11], n15, 31) ^ term_one(s[11], n15, 19)
         ^ term_one(s[11], n15, 16);
  endfunction

endpackage

/* design/ccrc_core.sv */
// Round pipeline: input register, one stage per add-xor-rotate step, parity compare.
// Depends on ccrc_pkg for the state types and the round and parity functions.
`timescale 1ns / 1ps

module ccrc_core import ccrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  item_t     item,
  input  key_t      key,
  input  logic      take,
  output logic      accept,
  output core_out_t core_out
);

  localparam int unsigned LAST = NUM_STEPS + 1;

  logic                en;
  logic [LAST:0]       v;
  logic [LAST:0]       rs;
  state_t              st [NUM_STEPS+1];
  logic                ip [IP_STEP+1:NUM_STEPS];
  kept_b_t             nb [IP_STEP+1:NUM_STEPS];
  logic                agree_q;

  // Whole pipeline moves together whenever the last stage is free or draining
  assign en     = !v[LAST] || take;
  assign accept = en;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAST-1:0], item_valid};
    end
  end

  // Advance restart flags and load the initial state
  always_ff @(posedge clk) begin
    if (en) begin
      rs    <= {rs[LAST-1:0], item.restart};
      st[0] <= init_state(key, item);
    end
  end

  // One round step per stage
  for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= chacha_step(st[k-1], k - 1);
      end
    end
  end

  // Take input parity and negated b words after the first column half
  always_ff @(posedge clk) begin
    if (en) begin
      ip[IP_STEP+1] <= mask_parity(st[IP_STEP]);
      nb[IP_STEP+1] <= {neg32(st[IP_STEP][7]), neg32(st[IP_STEP][6]),
                        neg32(st[IP_STEP][4])};
    end
  end

  // Carry them alongside the remaining steps
  for (genvar k = IP_STEP + 2; k <= NUM_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        ip[k] <= ip[k-1];
        nb[k] <= nb[k-1];
      end
    end
  end

  // Compare input parity against the approximated output parity
  always_ff @(posedge clk) begin
    if (en) begin
      agree_q <= (ip[NUM_STEPS] == output_parity(st[NUM_STEPS], nb[NUM_STEPS]));
    end
  end

  assign core_out = '{valid: v[LAST], restart: rs[LAST], agree: agree_q};

endmodule

/* design/chacha_reduced_round_correlation_counter_top.sv */
// Reduced-round ChaCha linear-distinguisher agreement counter. Each nonce beat builds a
// fresh ChaCha state from sigma, the 256-bit key in registers 0 to 3 and the nonce,
// runs three double rounds and one more column round, and reports whether the masked
// input parity matches the carry-approximated output parity, with a saturating count
// of agreements that the restart bit clears. One beat is accepted every cycle unless a
// stalled result holds the pipeline; each result passes the input register, the 28
// add-xor-rotate stages of the rounds and the parity and count stages. Key writes take
// effect for beats accepted after the write; write them only while no beat is in flight.
`timescale 1ns / 1ps
`include "chacha_reduced_round_correlation_counter_top_defines.svh"

module chacha_reduced_round_correlation_counter_top import ccrc_pkg::*; #(
  parameter int COUNT_WIDTH = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  item_t                      item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output result_t                    result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [63:0]                cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

  key_t                   key;
  core_out_t              core_out;
  logic                   accept;
  logic                   take;
  logic                   load;
  logic [COUNT_WIDTH-1:0] tally;
  logic [COUNT_WIDTH-1:0] tally_base;
  logic [COUNT_WIDTH-1:0] tally_next;

  assign cfg_ready = 1'b1;

  // Hold key words
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_01: key[0] <= cfg_data;
        REG_KEY_23: key[1] <= cfg_data;
        REG_KEY_45: key[2] <= cfg_data;
        REG_KEY_67: key[3] <= cfg_data;
      endcase
    end
  end

  ccrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .key       (key),
    .take      (take),
    .accept    (accept),
    .core_out  (core_out)
  );

  assign item_stall = !accept;
  assign take       = !result_valid || !result_stall;
  assign load       = core_out.valid && take;

  // Clear on restart, then count an agreement unless saturated
  always_comb begin
    tally_base = core_out.restart ? '0 : tally;
    tally_next = (core_out.agree && tally_base != TALLY_MAX)
               ? tally_base + COUNT_WIDTH'(1) : tally_base;
  end

  // Hold result valid and the running tally
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      tally        <= '0;
    end else begin
      if (take) begin
        result_valid <= core_out.valid;
      end
      if (load) begin
        tally <= tally_next;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (load) begin
      result <= '{agree: core_out.agree, agree_count: 33'(tally_next)};
    end
  end

  `CCRC_ASSERT_SAME(a_stall_only_when_full, item_stall, result_valid && result_stall)
  `CCRC_ASSERT_NEXT(a_tally_holds_idle, !load, $stable(tally))
  `CCRC_ASSERT_NEXT(a_tally_no_decrease, load && !core_out.restart, tally >= $past(tally))
  `CCRC_ASSERT_NEXT(a_restart_agree, load && core_out.restart && core_out.agree,
                    tally == COUNT_WIDTH'(1))
  `CCRC_ASSERT_NEXT(a_restart_miss, load && core_out.restart && !core_out.agree, tally == '0)

endmodule
